// ===== src/ncdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Normal CDF approximation package
// Shared widths, fixed-point constants and the exp base table.
// ----------------------------------------------------------------------------
package ncdf_pkg;

   localparam int X_FRAC_BITS_DEF = 12;
   localparam int Q_W             = 31;

   localparam logic [27:0] K_Q30     = 28'd248723596;
   localparam logic [28:0] C_PHI_Q30 = 29'd428361012;
   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [30:0] CE_Q30    = 31'd1428371291;
   localparam logic signed [33:0] CD_Q30 = -34'sd1955558716;
   localparam logic signed [33:0] CC_Q30 = 34'sd1912847369;
   localparam logic signed [33:0] CB_Q30 = -34'sd382857446;
   localparam logic signed [33:0] CA_Q30 = 34'sd342933307;
   localparam logic [26:0] DIV3_MUL  = 27'd89478486;

   // exp(-1/16) by the fourth-order series
   localparam longint unsigned SER_ONE = 64'd1 << 30;
   localparam longint unsigned SER_R   = 64'd1 << 26;
   localparam longint unsigned SER_W4  = SER_ONE - SER_R / 4;
   localparam longint unsigned SER_W3  = SER_ONE - (SER_R * SER_W4) / (3 * SER_ONE);
   localparam longint unsigned SER_W2  = SER_ONE - (SER_R * SER_W3) / (2 * SER_ONE);
   localparam longint unsigned SER_W1  = SER_ONE - (SER_R * SER_W2) / SER_ONE;

   typedef logic [7:0][30:0] base_tab_type;

   function automatic base_tab_type make_bases();
      base_tab_type    tab;
      longint unsigned b;
      tab[0] = 31'(SER_W1);
      for (int i = 1; i < 8; i++) begin
         b = 64'(tab[i-1]);
         tab[i] = 31'((b * b + (64'd1 << 29)) >> 30);
      end
      return tab;
   endfunction

   localparam base_tab_type EXP_BASE = make_bases();

endpackage

// ===== src/ncdf_div.sv =====
// ----------------------------------------------------------------------------
// Reciprocal divider
// Restoring division of 2^60 + den/2 by den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ncdf_div import ncdf_pkg::*; #(
   parameter int DEN_W  = 33,
   parameter int SIDE_W = 36
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STEPS = Q_W;

   logic              v_ff [STEPS+1];
   logic [DEN_W-1:0]  r_ff [STEPS+1];
   logic [DEN_W-1:0]  d_ff [STEPS+1];
   logic [STEPS-1:0]  n_ff [STEPS+1];
   logic [STEPS-1:0]  q_ff [STEPS+1];
   logic [SIDE_W-1:0] s_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= DEN_W'(in_den >> 32) + DEN_W'(64'd1 << 29);
         d_ff[0] <= in_den;
         n_ff[0] <= in_den[31:1];
         q_ff[0] <= '0;
         s_ff[0] <= in_side;
      end
   end

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic [DEN_W:0]   rem;
      logic             ge;
      logic [DEN_W-1:0] r_in;
      logic [STEPS-1:0] q_in;

      always_comb begin
         rem  = {r_ff[g], n_ff[g][STEPS-1-g]};
         ge   = rem >= {1'b0, d_ff[g]};
         r_in = ge ? DEN_W'(rem - {1'b0, d_ff[g]}) : DEN_W'(rem);
         q_in = {q_ff[g][STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (en) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[g+1] <= r_in;
            d_ff[g+1] <= d_ff[g];
            n_ff[g+1] <= n_ff[g];
            q_ff[g+1] <= q_in;
            s_ff[g+1] <= s_ff[g];
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_quot  = q_ff[STEPS];
   assign out_side  = s_ff[STEPS];

endmodule

// ===== src/normal_cdf_approx_top.sv =====
// ----------------------------------------------------------------------------
// Normal CDF approximation, top level
// Throughput: one beat per cycle while no result waits in the skid register;
//   the divider stages and 16 work stages each take a new beat every cycle
//   while not stalled, and a skid register keeps one result.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module normal_cdf_approx_top import ncdf_pkg::*; #(
   parameter int X_FRAC_BITS = X_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_x_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_probability
);

   localparam int SHIFT  = 16 - X_FRAC_BITS;
   localparam int A16_W  = 32 - X_FRAC_BITS;
   localparam int KP_W   = 28 + A16_W;
   localparam int SQ_W   = 2 * A16_W;
   localparam int DEN_W  = (45 - X_FRAC_BITS > 32) ? 45 - X_FRAC_BITS : 32;
   localparam int SIDE_W = 36;
   localparam int NWORK  = 16;

   typedef struct packed {
      logic        pos;
      logic        far;
      logic [7:0]  m;
      logic [25:0] r;
      logic [30:0] t;
      logic [61:0] ep;
      logic [63:0] pp;
      logic        pneg;
      logic [30:0] q;
      logic [30:0] ev;
      logic [61:0] tp;
      logic [15:0] res;
   } work_type;

   function automatic logic [33:0] rnd30(input logic [63:0] x);
      return 34'((x + 64'(1 << 29)) >> 30);
   endfunction

   function automatic logic [30:0] bsel(input logic [7:0] m, input int unsigned k);
      return m[k] ? EXP_BASE[k] : ONE_Q30;
   endfunction

   function automatic work_type work_step(input int unsigned idx, input work_type a);
      work_type           b;
      logic [30:0]        w;
      logic [32:0]        mag;
      logic signed [33:0] p;
      logic signed [33:0] coef;
      logic [32:0]        pabs;
      logic [32:0]        tail;
      logic [19:0]        t16;
      logic [16:0]        res;
      b = a;
      // exp(-r) series and power-of-two scaling
      if (idx == 0) begin
         w    = ONE_Q30 - 31'(a.r >> 2);
         b.ep = 62'(a.r) * 62'(w);
      end else if (idx == 1) begin
         b.ep = 62'(a.ep[56:30]) * 62'(DIV3_MUL);
      end else if (idx == 2) begin
         w    = ONE_Q30 - 31'(a.ep >> 28);
         b.ep = 62'(a.r) * 62'(w);
      end else if (idx == 3) begin
         w    = ONE_Q30 - 31'(a.ep >> 31);
         b.ep = 62'(a.r) * 62'(w);
      end else if (idx == 4) begin
         w    = ONE_Q30 - 31'(a.ep >> 30);
         b.ep = 62'(w) * 62'(bsel(a.m, 0));
      end else if (idx <= 11) begin
         w    = 31'(rnd30(64'(a.ep)));
         b.ep = 62'(w) * 62'(bsel(a.m, idx - 4));
      end else if (idx == 12) begin
         b.ev = a.far ? '0 : 31'(rnd30(64'(a.ep)));
      end
      // Horner polynomial in t
      case (idx)
         1:       coef = CD_Q30;
         2:       coef = CC_Q30;
         3:       coef = CB_Q30;
         4:       coef = CA_Q30;
         default: coef = '0;
      endcase
      mag = 33'(rnd30(a.pp));
      p   = coef + (a.pneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));
      pabs = p[33] ? 33'(-p) : 33'(p);
      if (idx == 0) begin
         b.pp   = 64'(a.t) * 64'(CE_Q30);
         b.pneg = 1'b0;
      end else if (idx <= 4) begin
         b.pneg = p[33];
         b.pp   = 64'(a.t) * 64'(pabs);
      end else if (idx == 5) begin
         b.q = p[33] ? '0 : 31'(p);
      end
      // tail and final probability
      tail = 33'(rnd30(64'(a.tp)));
      t16  = 20'((34'(tail) + 34'(8192)) >> 14);
      if (idx == 13) begin
         b.tp = 62'(C_PHI_Q30) * 62'(a.ev);
      end else if (idx == 14) begin
         w    = 31'(rnd30(64'(a.tp)));
         b.tp = 62'(w) * 62'(a.q);
      end else if (idx == 15) begin
         if (a.pos) begin
            res = (t16 >= 20'd65536) ? 17'd0 : 17'(20'd65536 - t16);
         end else begin
            res = (t16 > 20'd65535) ? 17'd65535 : 17'(t16);
         end
         b.res = (res > 17'd65535) ? 16'hFFFF : res[15:0];
      end
      return b;
   endfunction

   logic             en;
   logic             f1_v_ff;
   logic             f1_v_in;
   logic [A16_W-1:0] f1_a16_ff;
   logic [A16_W-1:0] f1_a16_in;
   logic             f1_pos_ff;
   logic             f1_pos_in;
   logic [15:0]      ax;

   logic             f2_v_ff;
   logic [KP_W-1:0]  f2_kp_ff;
   logic [KP_W-1:0]  f2_kp_in;
   logic [SIDE_W-1:0] f2_side_ff;
   logic [SIDE_W-1:0] f2_side_in;
   logic [SQ_W-1:0]  sq;
   logic [63:0]      u64;
   logic [KP_W:0]    kpr;
   logic [DEN_W-1:0] den;

   logic              div_v;
   logic [Q_W-1:0]    div_q;
   logic [SIDE_W-1:0] div_side;
   work_type          head;

   work_type wk_ff [NWORK];
   work_type wk_in [NWORK];
   logic     wv_ff [NWORK];
   logic     wv_in [NWORK];

   logic        rsp_v_ff;
   logic [15:0] rsp_d_ff;
   logic        skid_v_ff;
   logic [15:0] skid_d_ff;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // front end: magnitude, scaled |x|
   always_comb begin
      ax        = req_x_value[15] ? 16'(-req_x_value) : 16'(req_x_value);
      f1_v_in   = req_valid;
      f1_pos_in = !req_x_value[15] && (req_x_value != 16'sd0);
      f1_a16_in = {ax, SHIFT'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= f1_v_in;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_comb begin
      f2_kp_in   = KP_W'(f1_a16_ff) * KP_W'(K_Q30);
      sq         = SQ_W'(f1_a16_ff) * SQ_W'(f1_a16_ff);
      u64        = 64'(sq) >> 3;
      f2_side_in = {f1_pos_ff, |u64[63:34], u64[33:26], u64[25:0]};
      kpr        = (KP_W+1)'(f2_kp_ff) + (KP_W+1)'(32768);
      den        = DEN_W'(kpr >> 16) + DEN_W'(64'd1 << 30);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_a16_ff  <= f1_a16_in;
         f1_pos_ff  <= f1_pos_in;
         f2_kp_ff   <= f2_kp_in;
         f2_side_ff <= f2_side_in;
      end
   end

   ncdf_div #(
      .DEN_W  (DEN_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f2_v_ff),
      .in_den    (den),
      .in_side   (f2_side_ff),
      .out_valid (div_v),
      .out_quot  (div_q),
      .out_side  (div_side)
   );

   always_comb begin
      head      = '0;
      head.pos  = div_side[35];
      head.far  = div_side[34];
      head.m    = div_side[33:26];
      head.r    = div_side[25:0];
      head.t    = div_q;
      wk_in[0]  = work_step(0, head);
      wv_in[0]  = div_v;
      for (int i = 1; i < NWORK; i++) begin
         wk_in[i] = work_step(i, wk_ff[i-1]);
         wv_in[i] = wv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NWORK; i++) wv_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < NWORK; i++) wv_ff[i] <= wv_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NWORK; i++) wk_ff[i] <= wk_in[i];
      end
   end

   // output register with one-beat skid; hold the pipe while the skid is full
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || !rsp_stall) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff <= wv_ff[NWORK-1];
         end
      end else if (wv_ff[NWORK-1] && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || !rsp_stall) begin
         rsp_d_ff <= skid_v_ff ? skid_d_ff : wk_ff[NWORK-1].res;
      end else if (en) begin
         skid_d_ff <= wk_ff[NWORK-1].res;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_probability = rsp_d_ff;

endmodule
